FILE: rtl/core/fcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, codes and constants of the floppy controller command phase.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [1:0] REG_DISK_PRESENT  = 2'd0;
    localparam logic [1:0] REG_WRITE_PROTECT = 2'd1;
    localparam logic [1:0] REG_TWO_SIDED     = 2'd2;

    localparam logic [1:0] OP_STATUS  = 2'd0;
    localparam logic [1:0] OP_DATA_RD = 2'd1;
    localparam logic [1:0] OP_DATA_WR = 2'd2;

    localparam logic [4:0] CODE_TRACK_RD     = 5'h02;
    localparam logic [4:0] CODE_TIMING       = 5'h03;
    localparam logic [4:0] CODE_SENSE_DRIVE  = 5'h04;
    localparam logic [4:0] CODE_SECTOR_WR    = 5'h05;
    localparam logic [4:0] CODE_SECTOR_RD    = 5'h06;
    localparam logic [4:0] CODE_HOME         = 5'h07;
    localparam logic [4:0] CODE_SENSE_INT    = 5'h08;
    localparam logic [4:0] CODE_WRITE_DELETED = 5'h09;
    localparam logic [4:0] CODE_HEADER_RD    = 5'h0A;
    localparam logic [4:0] CODE_READ_DELETED = 5'h0C;
    localparam logic [4:0] CODE_FORMAT       = 5'h0D;
    localparam logic [4:0] CODE_STEP_TO      = 5'h0F;
    localparam logic [4:0] CODE_SCAN_EQ      = 5'h11;
    localparam logic [4:0] CODE_SCAN_LOW     = 5'h19;
    localparam logic [4:0] CODE_SCAN_HIGH    = 5'h1D;

    localparam logic [3:0] POS_CODE = 4'd0;
    localparam logic [3:0] POS_UNIT = 4'd1;
    localparam logic [3:0] POS_ARG  = 4'd2;
    localparam logic [3:0] POS_SECT = 4'd4;
    localparam logic [3:0] POS_SIZE = 4'd5;
    localparam logic [3:0] CMD_MAX  = 4'd9;

    localparam logic [7:0] MSR_COMMAND = 8'h80;
    localparam logic [7:0] MSR_BUSY    = 8'h10;
    localparam logic [7:0] MSR_RESULT  = 8'hD0;
    localparam logic [7:0] RD_NONE     = 8'hFF;
    localparam logic [7:0] RD_WRITE    = 8'h00;

    localparam logic [7:0] ST0_INVALID = 8'h80;
    localparam logic [7:0] ST0_NOT_RDY = 8'h48;
    localparam logic [7:0] ST1_NO_ADDR = 8'h01;
    localparam logic [7:0] ST0_SEEK_OK = 8'h20;
    localparam logic [7:0] ST0_SEEK_NR = 8'h68;
    localparam logic [7:0] ST0_RESET_0 = 8'hC0;
    localparam logic [7:0] ST0_RESET_1 = 8'hC1;
    localparam logic [7:0] ST3_WPROT   = 8'h40;
    localparam logic [7:0] ST3_READY   = 8'h20;
    localparam logic [7:0] ST3_TRACK0  = 8'h10;
    localparam logic [7:0] ST3_TWO_SIDE = 8'h08;

    typedef struct packed {
        logic [1:0] disk_present;
        logic [1:0] write_protect;
        logic [1:0] two_sided;
    } cfg_t;

    typedef struct packed {
        logic       result_phase;
        logic [3:0] cmd_count;
        logic [2:0] res_pos;
        logic [2:0] res_len;
    } status_t;

    function automatic logic [3:0] param_count(input logic [4:0] code);
        logic [3:0] n;
        case (code) inside
            CODE_TRACK_RD, CODE_SECTOR_WR, CODE_SECTOR_RD, CODE_WRITE_DELETED,
            CODE_READ_DELETED, CODE_SCAN_EQ, CODE_SCAN_LOW, CODE_SCAN_HIGH:
                n = 4'd8;
            CODE_HEADER_RD, CODE_HOME, CODE_SENSE_DRIVE:
                n = 4'd1;
            CODE_FORMAT:
                n = 4'd5;
            CODE_TIMING, CODE_STEP_TO:
                n = 4'd2;
            default:
                n = 4'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/fcc_apb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcc_apb_regs
// Configuration registers for disk presence, write protection and sides.
// ----------------------------------------------------------------------------
module fcc_apb_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [fcc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [fcc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [fcc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output fcc_pkg::cfg_t                         cfg
);
    import fcc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DISK_PRESENT:  cfg_next.disk_present  = pwdata[1:0];
                REG_WRITE_PROTECT: cfg_next.write_protect = pwdata[1:0];
                REG_TWO_SIDED:     cfg_next.two_sided     = pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_DISK_PRESENT:  prdata[1:0] = cfg_reg.disk_present;
            REG_WRITE_PROTECT: prdata[1:0] = cfg_reg.write_protect;
            REG_TWO_SIDED:     prdata[1:0] = cfg_reg.two_sided;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/fcc_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcc_engine
// Command collection, command execution, result readback and drive state.
// ----------------------------------------------------------------------------
module fcc_engine #(
    parameter int DRIVES = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire fcc_pkg::cfg_t cfg,
    input  wire logic          accept,
    input  wire logic [1:0]    operation,
    input  wire logic [7:0]    write_byte,
    output logic      [7:0]    read_byte,
    output fcc_pkg::status_t   status
);
    import fcc_pkg::*;

    localparam int         DIDX_W    = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam logic [2:0] DRIVES_W3 = 3'(DRIVES);

    typedef enum logic {PH_COMMAND, PH_RESULT} phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] pos_reg, pos_next;
    logic [2:0] len_reg, len_next;
    logic [7:0] cmd0_reg, cmd0_next;
    logic [7:0] cmd1_reg, cmd1_next;
    logic [7:0] cmd2_reg, cmd2_next;
    logic [7:0] cmd4_reg, cmd4_next;
    logic [7:0] cmd5_reg, cmd5_next;
    logic [7:0] res_reg   [7];
    logic [7:0] res_next  [7];
    logic [7:0] track_reg [DRIVES];
    logic [7:0] track_next[DRIVES];
    logic       pend_reg  [DRIVES];
    logic       pend_next [DRIVES];
    logic [7:0] stat_reg  [DRIVES];
    logic [7:0] stat_next [DRIVES];

    logic [7:0]        e0, e1, e2;
    logic [4:0]        code;
    logic [1:0]        drv;
    logic              side;
    logic              drv_ok;
    logic              disk;
    logic [DIDX_W-1:0] didx;
    logic [7:0]        trk;
    logic [7:0]        nr;
    logic [7:0]        st3;
    logic [2:0]        pos_inc;

    assign e0      = (cnt_reg == POS_CODE) ? write_byte : cmd0_reg;
    assign e1      = (cnt_reg == POS_UNIT) ? write_byte : cmd1_reg;
    assign e2      = (cnt_reg == POS_ARG)  ? write_byte : cmd2_reg;
    assign code    = e0[4:0];
    assign drv     = e1[1:0];
    assign side    = e1[2];
    assign drv_ok  = {1'b0, drv} < DRIVES_W3;
    assign disk    = !drv[1] && cfg.disk_present[drv[0]];
    assign didx    = drv[DIDX_W-1:0];
    assign trk     = drv_ok ? track_reg[didx] : 8'h00;
    assign nr      = ST0_NOT_RDY | {5'b0, side, drv};
    assign pos_inc = pos_reg + 3'd1;

    always_comb begin
        st3 = {5'b0, side, drv};
        if (disk) begin
            st3 = st3 | ST3_READY;
            if (cfg.two_sided[drv[0]]) st3 = st3 | ST3_TWO_SIDE;
            if (trk == 8'h00) st3 = st3 | ST3_TRACK0;
            if (cfg.write_protect[drv[0]]) st3 = st3 | ST3_WPROT;
        end
    end

    always_comb begin
        logic found;
        found      = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        cmd0_next  = cmd0_reg;
        cmd1_next  = cmd1_reg;
        cmd2_next  = cmd2_reg;
        cmd4_next  = cmd4_reg;
        cmd5_next  = cmd5_reg;
        res_next   = res_reg;
        track_next = track_reg;
        pend_next  = pend_reg;
        stat_next  = stat_reg;
        read_byte  = RD_NONE;
        if (accept) begin
            case (operation)
                OP_STATUS: begin
                    if (phase_reg == PH_RESULT) begin
                        read_byte = MSR_RESULT;
                    end else begin
                        read_byte = MSR_COMMAND | ((cnt_reg != 4'd0) ? MSR_BUSY : 8'h00);
                    end
                end
                OP_DATA_RD: begin
                    if (phase_reg == PH_RESULT && pos_reg < len_reg) begin
                        read_byte = res_reg[pos_reg];
                        pos_next  = pos_inc;
                        if (pos_inc >= len_reg) begin
                            phase_next = PH_COMMAND;
                            cnt_next   = 4'd0;
                        end
                    end
                end
                OP_DATA_WR: begin
                    read_byte = RD_WRITE;
                    if (phase_reg == PH_COMMAND && cnt_reg < CMD_MAX) begin
                        if (cnt_reg == POS_CODE) cmd0_next = write_byte;
                        if (cnt_reg == POS_UNIT) cmd1_next = write_byte;
                        if (cnt_reg == POS_ARG)  cmd2_next = write_byte;
                        if (cnt_reg == POS_SECT) cmd4_next = write_byte;
                        if (cnt_reg == POS_SIZE) cmd5_next = write_byte;
                        cnt_next = cnt_reg + 4'd1;
                        if (cnt_reg >= param_count(code)) begin
                            phase_next = PH_RESULT;
                            pos_next   = 3'd0;
                            len_next   = 3'd1;
                            res_next[0] = ST0_INVALID;
                            unique case (code) inside
                                CODE_TRACK_RD, CODE_SECTOR_WR, CODE_SECTOR_RD,
                                CODE_WRITE_DELETED, CODE_READ_DELETED: begin
                                    if (!disk) begin
                                        len_next    = 3'd7;
                                        res_next[0] = nr;
                                        res_next[1] = 8'h00;
                                        res_next[2] = 8'h00;
                                        res_next[3] = cmd2_reg;
                                        res_next[4] = {7'b0, side};
                                        res_next[5] = cmd4_reg;
                                        res_next[6] = cmd5_reg;
                                    end
                                end
                                CODE_HEADER_RD: begin
                                    if (!disk) begin
                                        len_next    = 3'd7;
                                        res_next[0] = nr;
                                        res_next[1] = ST1_NO_ADDR;
                                        res_next[2] = 8'h00;
                                        res_next[3] = 8'h00;
                                        res_next[4] = 8'h00;
                                        res_next[5] = 8'h00;
                                        res_next[6] = 8'h00;
                                    end
                                end
                                CODE_FORMAT: begin
                                    if (!disk) begin
                                        len_next    = 3'd7;
                                        res_next[0] = nr;
                                        res_next[1] = 8'h00;
                                        res_next[2] = 8'h00;
                                        res_next[3] = trk;
                                        res_next[4] = {7'b0, side};
                                        res_next[5] = 8'h00;
                                        res_next[6] = e2;
                                    end
                                end
                                CODE_HOME, CODE_STEP_TO: begin
                                    res_next   = res_reg;
                                    len_next   = len_reg;
                                    pos_next   = pos_reg;
                                    phase_next = PH_COMMAND;
                                    cnt_next   = 4'd0;
                                    if (drv_ok) begin
                                        track_next[didx] = (code == CODE_STEP_TO) ? e2 : 8'h00;
                                        pend_next[didx]  = 1'b1;
                                        stat_next[didx]  = (disk ? ST0_SEEK_OK : ST0_SEEK_NR)
                                                         | {6'b0, drv};
                                    end
                                end
                                CODE_TIMING: begin
                                    res_next   = res_reg;
                                    len_next   = len_reg;
                                    pos_next   = pos_reg;
                                    phase_next = PH_COMMAND;
                                    cnt_next   = 4'd0;
                                end
                                CODE_SENSE_INT: begin
                                    for (int d = 0; d < DRIVES; d++) begin
                                        if (!found && pend_reg[d]) begin
                                            found        = 1'b1;
                                            pend_next[d] = 1'b0;
                                            res_next[0]  = stat_reg[d];
                                            res_next[1]  = track_reg[d];
                                            len_next     = 3'd2;
                                        end
                                    end
                                end
                                CODE_SENSE_DRIVE: begin
                                    res_next[0] = st3;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: read_byte = RD_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COMMAND;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            for (int d = 0; d < DRIVES; d++) begin
                track_reg[d] <= '0;
                pend_reg[d]  <= (d < 2);
                stat_reg[d]  <= (d == 0) ? ST0_RESET_0 : ((d == 1) ? ST0_RESET_1 : 8'h00);
            end
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            track_reg <= track_next;
            pend_reg  <= pend_next;
            stat_reg  <= stat_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd0_reg <= cmd0_next;
        cmd1_reg <= cmd1_next;
        cmd2_reg <= cmd2_next;
        cmd4_reg <= cmd4_next;
        cmd5_reg <= cmd5_next;
        res_reg  <= res_next;
    end

    assign status.result_phase = (phase_reg == PH_RESULT);
    assign status.cmd_count    = cnt_reg;
    assign status.res_pos      = pos_reg;
    assign status.res_len      = len_reg;

endmodule
`default_nettype wire

FILE: rtl/core/floppy_controller_command_phase.sv
`default_nettype none
// ----------------------------------------------------------------------------
// floppy_controller_command_phase
// Host bus view of a floppy controller: status reads, command byte writes,
// command execution and result byte readback.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                              Notes
// s_        in         s_valid s_ready s_operation          one bus access
//                      s_write_byte                         per transfer
// m_        out        m_valid m_ready m_read_byte          one byte per access
// apb       in/out     psel penable pwrite paddr pwdata     registers at 0, 4, 8
//                      prdata pready
//
// Each access's byte is registered and presented in the cycle after the
// transfer; a new access is taken in every cycle unless m_ready stalls.
// The output register sets the rate: s_ready is high while it is empty or
// being drained, so a stall on m_ready holds the input after one item.
// Reset clears the phase, counts, tracks and pending flags, and marks drives 0 and 1
// with a pending seek status.
// ----------------------------------------------------------------------------
module floppy_controller_command_phase #(
    parameter int DRIVES = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [fcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [fcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_operation,
    input  wire logic [7:0]                      s_write_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [7:0]                      m_read_byte
);
    import fcc_pkg::*;

    cfg_t       cfg;
    status_t    eng_status;
    logic       accept;
    logic [7:0] rd_byte;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_read_byte_reg;

    fcc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcc_engine #(
        .DRIVES (DRIVES)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (accept),
        .operation  (s_operation),
        .write_byte (s_write_byte),
        .read_byte  (rd_byte),
        .status     (eng_status)
    );

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign m_valid_next = accept || (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;
    assign m_read_byte  = m_read_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_byte_reg <= rd_byte;
        end
    end

    a_cmd_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !eng_status.result_phase |-> eng_status.cmd_count < CMD_MAX)
        else $error("command count past the longest command");

    a_result_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_status.result_phase |-> eng_status.res_pos < eng_status.res_len)
        else $error("result position past result length");

    a_transfer_answered: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transfer produced no result");

    a_status_in_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation == OP_STATUS && eng_status.result_phase)
        |=> m_read_byte == MSR_RESULT)
        else $error("main status wrong in result phase");

endmodule
`default_nettype wire
